[rtl/uv_sphere_vertex_generator_assert.svh]
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Clocked, reset-qualified property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH

// property must hold at every clock edge outside reset
`define UVS_ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define UVS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared widths, register codes, pipeline types and trig/rounding helpers.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int RING_W = 11;   // clamped ring, up to ring_count + 1
	localparam int SEG_W  = 10;   // clamped segment
	localparam int NUM_W  = 26;   // divider dividend
	localparam int DEN_W  = 13;   // divider divisor
	localparam int QUO_W  = 15;   // divider quotient, one bit per stage

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	typedef enum logic [1:0] {
		REG_SEGMENT_COUNT = 2'd0,
		REG_RING_COUNT    = 2'd1,
		REG_RADIUS_SCALE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [14:0] s;
		logic [14:0] c;
	} trig_t;

	// per-vertex data that rides along the pipeline
	typedef struct packed {
		logic [14:0] tex_u;
		logic [14:0] tex_v;
		logic [19:0] vnum;
		logic        quad;
	} attr_t;

	typedef struct packed {
		logic [19:0] vnum;
		logic        quad;
	} side_t;

	// Q30 angle in [0, pi/2) -> Q14 sine and cosine, seven Taylor terms.
	// Elaboration only: builds the quarter-wave tables.
	function automatic trig_t quarter_trig(logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] st;
		logic [63:0] ct;
		longint      ss;
		longint      cs;
		trig_t       r;
		int          k;
		x2 = (x * x) >> 30;
		st = x;
		ct = ONE_Q30;
		ss = longint'(x);
		cs = longint'(ONE_Q30);
		for (k = 1; k <= 6; k++) begin
			st = ((st * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			ct = ((ct * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				ss = ss - longint'(st);
				cs = cs - longint'(ct);
			end else begin
				ss = ss + longint'(st);
				cs = cs + longint'(ct);
			end
		end
		if (ss < 0) ss = 0;
		if (cs < 0) cs = 0;
		r.s = 15'((ss + 32768) >>> 16);
		r.c = 15'((cs + 32768) >>> 16);
		return r;
	endfunction

	// signed product >> 14, round to nearest, ties away from zero
	function automatic logic signed [17:0] rnd14(logic signed [31:0] p);
		logic [31:0] mag;
		logic [17:0] r;
		mag = p[31] ? 32'(-p) : 32'(p);
		r   = 18'((mag + 32'd8192) >> 14);
		if (p[31]) rnd14 = $signed(-r);
		else       rnd14 = $signed(r);
	endfunction

endpackage

[rtl/uvs_div.sv]
// ----------------------------------------------------------------------------
// UV sphere pipelined divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module uvs_div #(
	parameter int N_W = 26,
	parameter int D_W = 13,
	parameter int Q_W = 15
) (
	input  logic           clk,
	input  logic           en,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic [Q_W-1:0] quo
);

	logic [D_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0] low_s [Q_W];
	logic [Q_W-1:0] quo_s [Q_W];

	// upper dividend bits are below den since the quotient fits Q_W bits
	logic [D_W-1:0] rem_in;
	assign rem_in = D_W'(num[N_W-1:Q_W]);

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [D_W-1:0] rem_prev;
		logic [Q_W-1:0] low_prev;
		logic [Q_W-1:0] quo_prev;
		logic [D_W:0]   trial;
		logic [D_W:0]   diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_prev = rem_in;
			assign low_prev = num[Q_W-1:0];
			assign quo_prev = '0;
		end else begin : g_next
			assign rem_prev = rem_s[k-1];
			assign low_prev = low_s[k-1];
			assign quo_prev = quo_s[k-1];
		end

		assign trial = {rem_prev, low_prev[Q_W-1]};
		assign ge    = trial >= {1'b0, den};
		assign diff  = trial - {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
				low_s[k] <= low_prev << 1;
				quo_s[k] <= {quo_prev[Q_W-2:0], ge};
			end
		end
	end

	assign quo = quo_s[Q_W-1];

endmodule

[rtl/uv_sphere_vertex_generator.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Grid point (ring, segment) in, full UV-sphere vertex out, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   item channel:   ring_index/segment_index with item_valid; a transaction
//                   completes when item_valid is high and item_stall is low.
//   vertex channel: position, normal, tangent, texture coordinate, linear
//                   vertex number and quad_starts with vertex_valid; the
//                   receiver holds vertex_stall high to keep a vertex.
//   APB port:       segment_count at 0x0, ring_count at 0x4, radius_scale at
//                   0x8; write only while no transaction is in flight.
// Pipeline: mask and clamp, the 15-stage restoring dividers (one quotient
//   bit per stage), lookup, fold, products, rounding, output register.
// Throughput: one vertex per cycle unless stalled; every stage advances together.
// Stall: while a finished vertex waits under vertex_stall the whole pipeline
//   holds and item_stall is raised; nothing is lost or repeated.
// Reset: all valid bits clear, registers return to 100 / 100 / 1.5.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
	parameter int INDEX_BITS       = 10,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [9:0]         ring_index,
	input  logic [9:0]         segment_index,
	// vertex channel
	output logic               vertex_valid,
	input  logic               vertex_stall,
	output logic signed [16:0] position_x,
	output logic signed [16:0] position_y,
	output logic signed [16:0] position_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic signed [15:0] tangent_x,
	output logic signed [15:0] tangent_z,
	output logic [14:0]        tex_u,
	output logic [14:0]        tex_v,
	output logic [19:0]        vertex_number,
	output logic               quad_starts
);

	localparam int PB = $clog2(SINE_TABLE_DEPTH);   // phase bits
	localparam int QB = PB - 2;                     // quarter-wave index bits
	localparam int QN = SINE_TABLE_DEPTH / 4;
	localparam logic [9:0] IDX_MASK =
		(INDEX_BITS >= 10) ? 10'h3FF : 10'((1 << INDEX_BITS) - 1);
	localparam int DLY = uvs_pkg::QUO_W;

	// ---------------- configuration registers ----------------
	logic [9:0]  seg_cnt_q;
	logic [9:0]  ring_cnt_q;
	logic [14:0] radius_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cnt_q  <= 10'd100;
			ring_cnt_q <= 10'd100;
			radius_q   <= 15'd6144;
		end else if (cfg_wr) begin
			case (uvs_pkg::reg_idx_t'(paddr[3:2]))
				uvs_pkg::REG_SEGMENT_COUNT: seg_cnt_q  <= pwdata[9:0];
				uvs_pkg::REG_RING_COUNT:    ring_cnt_q <= pwdata[9:0];
				uvs_pkg::REG_RADIUS_SCALE:  radius_q   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (uvs_pkg::reg_idx_t'(paddr[3:2]))
			uvs_pkg::REG_SEGMENT_COUNT: prdata = 32'(seg_cnt_q);
			uvs_pkg::REG_RING_COUNT:    prdata = 32'(ring_cnt_q);
			uvs_pkg::REG_RADIUS_SCALE:  prdata = 32'(radius_q);
			default:                    prdata = 32'd0;
		endcase
	end

	// effective counts: at least 3 segments, at least 1 ring
	logic [9:0]  segs;
	logic [10:0] rings1;   // rings + 1
	assign segs   = (seg_cnt_q < 10'd3) ? 10'd3 : seg_cnt_q;
	assign rings1 = ((ring_cnt_q == 10'd0) ? 11'd1 : {1'b0, ring_cnt_q}) + 11'd1;

	// ---------------- pipeline control ----------------
	// single enable: the pipeline holds only while the output is stuck
	logic en;
	assign en         = !(vertex_valid && vertex_stall);
	assign item_stall = !en;

	// ---------------- stage 1: mask and clamp ----------------
	logic                       valid_s1;
	logic [uvs_pkg::RING_W-1:0] ring_s1;
	logic [uvs_pkg::SEG_W-1:0]  seg_s1;
	logic [9:0]                 ring_m;
	logic [9:0]                 seg_m;

	assign ring_m = ring_index & IDX_MASK;
	assign seg_m  = segment_index & IDX_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_s1 <= ({1'b0, ring_m} > rings1) ? rings1 : {1'b0, ring_m};
			seg_s1  <= (seg_m > segs) ? segs : seg_m;
		end
	end

	// ---------------- division stages ----------------
	// all rounded quotients are floor((2*num + den) / (2*den))
	logic [uvs_pkg::NUM_W-1:0] num_pr, num_ps, num_tu, num_tv;
	logic [uvs_pkg::DEN_W-1:0] den_pr, den_seg, den_tv;
	logic [uvs_pkg::QUO_W-1:0] quo_pr, quo_ps, quo_tu, quo_tv;

	assign num_pr  = (uvs_pkg::NUM_W'(ring_s1) << (PB + 1)) + (uvs_pkg::NUM_W'(rings1) << 1);
	assign num_ps  = (uvs_pkg::NUM_W'(seg_s1) << (PB + 1)) + uvs_pkg::NUM_W'(segs);
	assign num_tu  = (uvs_pkg::NUM_W'(seg_s1) << 15) + uvs_pkg::NUM_W'(segs);
	assign num_tv  = (uvs_pkg::NUM_W'(ring_s1) << 15) + uvs_pkg::NUM_W'(rings1);
	assign den_pr  = uvs_pkg::DEN_W'(rings1) << 2;
	assign den_seg = uvs_pkg::DEN_W'(segs) << 1;
	assign den_tv  = uvs_pkg::DEN_W'(rings1) << 1;

	uvs_div #(.N_W(uvs_pkg::NUM_W), .D_W(uvs_pkg::DEN_W), .Q_W(uvs_pkg::QUO_W)) u_div_pr (
		.clk(clk), .en(en), .num(num_pr), .den(den_pr), .quo(quo_pr)
	);
	uvs_div #(.N_W(uvs_pkg::NUM_W), .D_W(uvs_pkg::DEN_W), .Q_W(uvs_pkg::QUO_W)) u_div_ps (
		.clk(clk), .en(en), .num(num_ps), .den(den_seg), .quo(quo_ps)
	);
	uvs_div #(.N_W(uvs_pkg::NUM_W), .D_W(uvs_pkg::DEN_W), .Q_W(uvs_pkg::QUO_W)) u_div_tu (
		.clk(clk), .en(en), .num(num_tu), .den(den_seg), .quo(quo_tu)
	);
	uvs_div #(.N_W(uvs_pkg::NUM_W), .D_W(uvs_pkg::DEN_W), .Q_W(uvs_pkg::QUO_W)) u_div_tv (
		.clk(clk), .en(en), .num(num_tv), .den(den_tv), .quo(quo_tv)
	);

	// vertex number and quad flag wait beside the dividers
	logic [21:0]    vnum_full;
	uvs_pkg::side_t side_in;
	uvs_pkg::side_t side_s2  [DLY];
	logic           valid_s2 [DLY];

	assign vnum_full    = 22'(ring_s1) * 22'({1'b0, segs} + 11'd1) + 22'(seg_s1);
	assign side_in.vnum = vnum_full[19:0];
	assign side_in.quad = (ring_s1 < rings1) && (seg_s1 < segs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DLY; k++) valid_s2[k] <= 1'b0;
		end else if (en) begin
			valid_s2[0] <= valid_s1;
			for (int k = 1; k < DLY; k++) valid_s2[k] <= valid_s2[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2[0] <= side_in;
			for (int k = 1; k < DLY; k++) side_s2[k] <= side_s2[k-1];
		end
	end

	// ---------------- quarter-wave tables ----------------
	logic [14:0] sin_rom [QN];
	logic [14:0] cos_rom [QN];

	for (genvar i = 0; i < QN; i++) begin : g_rom
		localparam logic [63:0] ANG =
			(uvs_pkg::HALF_PI_Q30 * 64'(4 * i)) / 64'(SINE_TABLE_DEPTH);
		localparam uvs_pkg::trig_t TRG = uvs_pkg::quarter_trig(ANG);
		assign sin_rom[i] = TRG.s;
		assign cos_rom[i] = TRG.c;
	end

	// ---------------- stage 3: table lookup ----------------
	logic          valid_s3;
	logic [14:0]   ra_s3, rb_s3, sa_s3, sb_s3;
	logic [1:0]    rq_s3, sq_s3;
	uvs_pkg::attr_t attr_s3;
	logic [PB-1:0] pr, ps;

	assign pr = quo_pr[PB-1:0];
	assign ps = quo_ps[PB-1:0];   // segment phase wraps at a full turn

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2[DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra_s3         <= sin_rom[pr[QB-1:0]];
			rb_s3         <= cos_rom[pr[QB-1:0]];
			rq_s3         <= pr[PB-1:PB-2];
			sa_s3         <= sin_rom[ps[QB-1:0]];
			sb_s3         <= cos_rom[ps[QB-1:0]];
			sq_s3         <= ps[PB-1:PB-2];
			attr_s3.tex_u <= quo_tu;
			attr_s3.tex_v <= quo_tv;
			attr_s3.vnum  <= side_s2[DLY-1].vnum;
			attr_s3.quad  <= side_s2[DLY-1].quad;
		end
	end

	// ---------------- stage 4: quadrant fold ----------------
	logic               valid_s4;
	logic signed [15:0] sr_s4, cr_s4, ss_s4, cs_s4;
	uvs_pkg::attr_t     attr_s4;
	logic signed [15:0] fr_s, fr_c, fs_s, fs_c;

	always_comb begin
		case (rq_s3)
			2'd0:    begin fr_s =  $signed({1'b0, ra_s3}); fr_c =  $signed({1'b0, rb_s3}); end
			2'd1:    begin fr_s =  $signed({1'b0, rb_s3}); fr_c = -$signed({1'b0, ra_s3}); end
			2'd2:    begin fr_s = -$signed({1'b0, ra_s3}); fr_c = -$signed({1'b0, rb_s3}); end
			default: begin fr_s = -$signed({1'b0, rb_s3}); fr_c =  $signed({1'b0, ra_s3}); end
		endcase
		case (sq_s3)
			2'd0:    begin fs_s =  $signed({1'b0, sa_s3}); fs_c =  $signed({1'b0, sb_s3}); end
			2'd1:    begin fs_s =  $signed({1'b0, sb_s3}); fs_c = -$signed({1'b0, sa_s3}); end
			2'd2:    begin fs_s = -$signed({1'b0, sa_s3}); fs_c = -$signed({1'b0, sb_s3}); end
			default: begin fs_s = -$signed({1'b0, sb_s3}); fs_c =  $signed({1'b0, sa_s3}); end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s4   <= fr_s;
			cr_s4   <= fr_c;
			ss_s4   <= fs_s;
			cs_s4   <= fs_c;
			attr_s4 <= attr_s3;
		end
	end

	// ---------------- stage 5: normal products ----------------
	logic               valid_s5;
	logic signed [31:0] px_s5, pz_s5;
	logic signed [15:0] ny_s5, tx_s5, tz_s5;
	uvs_pkg::attr_t     attr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5   <= sr_s4 * ss_s4;
			pz_s5   <= sr_s4 * cs_s4;
			ny_s5   <= cr_s4;
			tx_s5   <= cs_s4;
			tz_s5   <= -ss_s4;
			attr_s5 <= attr_s4;
		end
	end

	// ---------------- stage 6: round normals ----------------
	logic               valid_s6;
	logic signed [15:0] nx_s6, ny_s6, nz_s6, tx_s6, tz_s6;
	uvs_pkg::attr_t     attr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s6   <= 16'(uvs_pkg::rnd14(px_s5));
			nz_s6   <= 16'(uvs_pkg::rnd14(pz_s5));
			ny_s6   <= ny_s5;
			tx_s6   <= tx_s5;
			tz_s6   <= tz_s5;
			attr_s6 <= attr_s5;
		end
	end

	// ---------------- stage 7: radius products ----------------
	logic               valid_s7;
	logic signed [31:0] qx_s7, qy_s7, qz_s7;
	logic signed [15:0] nx_s7, ny_s7, nz_s7, tx_s7, tz_s7;
	uvs_pkg::attr_t     attr_s7;
	logic signed [15:0] rad;

	assign rad = $signed({1'b0, radius_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s7   <= nx_s6 * rad;
			qy_s7   <= ny_s6 * rad;
			qz_s7   <= nz_s6 * rad;
			nx_s7   <= nx_s6;
			ny_s7   <= ny_s6;
			nz_s7   <= nz_s6;
			tx_s7   <= tx_s6;
			tz_s7   <= tz_s6;
			attr_s7 <= attr_s6;
		end
	end

	// ---------------- stage 8: output register ----------------
	logic               valid_s8;
	logic signed [16:0] posx_s8, posy_s8, posz_s8;
	logic signed [15:0] nx_s8, ny_s8, nz_s8, tx_s8, tz_s8;
	uvs_pkg::attr_t     attr_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			posx_s8 <= 17'(uvs_pkg::rnd14(qx_s7));
			posy_s8 <= 17'(uvs_pkg::rnd14(qy_s7));
			posz_s8 <= 17'(uvs_pkg::rnd14(qz_s7));
			nx_s8   <= nx_s7;
			ny_s8   <= ny_s7;
			nz_s8   <= nz_s7;
			tx_s8   <= tx_s7;
			tz_s8   <= tz_s7;
			attr_s8 <= attr_s7;
		end
	end

	assign vertex_valid  = valid_s8;
	assign position_x    = posx_s8;
	assign position_y    = posy_s8;
	assign position_z    = posz_s8;
	assign normal_x      = nx_s8;
	assign normal_y      = ny_s8;
	assign normal_z      = nz_s8;
	assign tangent_x     = tx_s8;
	assign tangent_z     = tz_s8;
	assign tex_u         = attr_s8.tex_u;
	assign tex_v         = attr_s8.tex_v;
	assign vertex_number = attr_s8.vnum;
	assign quad_starts   = attr_s8.quad;

endmodule

[rtl/uvs_checker.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex generator port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_assert.svh"

module uvs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               vertex_valid,
	input logic               vertex_stall,
	input logic signed [15:0] normal_y,
	input logic [14:0]        tex_u,
	input logic [14:0]        tex_v,
	input logic [19:0]        vertex_number,
	input logic               quad_starts
);

	// input side backs up exactly when a finished vertex is held
	`UVS_ASSERT_HOLDS(a_stall_link, item_stall == (vertex_valid && vertex_stall), "item_stall mismatch")

	// a held vertex stays put
	`UVS_ASSERT_HOLDS(a_hold, (vertex_valid && vertex_stall) |=> (vertex_valid && $stable(vertex_number)), "held vertex changed")

	// a quad never starts on the last column or the bottom pole row
	`UVS_ASSERT_NEVER(a_quad_tex, vertex_valid && quad_starts && (tex_u >= 15'd16384 || tex_v >= 15'd16384), "quad at edge")

	// cosine of the ring angle stays within unit range
	`UVS_ASSERT_NEVER(a_ny_range, vertex_valid && (normal_y > 16'sd16384 || normal_y < -16'sd16384), "normal_y out of range")

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid points through the item channel under random gaps and
// back-pressure, predicts each vertex in integer math and checks every field.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic [9:0] ring;
		logic [9:0] seg;
	} grid_pt_t;

	typedef struct {
		logic signed [16:0] pos_x, pos_y, pos_z;
		logic signed [15:0] nrm_x, nrm_y, nrm_z;
		logic signed [15:0] tan_x, tan_z;
		logic [14:0]        tu, tv;
		logic [19:0]        vnum;
		logic               quad;
	} vertex_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [9:0]  ring_index = '0, segment_index = '0;
	logic        vertex_valid;
	logic        vertex_stall = 1'b0;
	logic signed [16:0] position_x, position_y, position_z;
	logic signed [15:0] normal_x, normal_y, normal_z, tangent_x, tangent_z;
	logic [14:0] tex_u, tex_v;
	logic [19:0] vertex_number;
	logic        quad_starts;

	// shadow copy of the configuration registers
	int unsigned seg_count_q = 100, ring_count_q = 100, radius_q = 6144;

	grid_pt_t pending_pts[$];
	vertex_t  expected_vertices[$];
	int       fail_count = 0;
	bit       steady = 1'b0;   // phase with no idling on either side
	int       gap_left = 0, stall_left = 0, quiet_cycles = 0;

	uv_sphere_vertex_generator dut (.*);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor
	// quarter-wave Taylor series in Q30, rounded to Q14
	function automatic void quarter_sin_cos(input logic [63:0] x, output longint s,
			output longint c);
		logic [63:0] x2, st, ct;
		longint ss, cs;
		x2 = (x * x) >> 30;
		st = x;
		ct = 64'd1 << 30;
		ss = longint'(x);
		cs = longint'(ct);
		for (int k = 1; k <= 6; k++) begin
			st = ((st * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			ct = ((ct * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				ss -= longint'(st);
				cs -= longint'(ct);
			end else begin
				ss += longint'(st);
				cs += longint'(ct);
			end
		end
		if (ss < 0) ss = 0;
		if (cs < 0) cs = 0;
		s = (ss + 32768) >>> 16;
		c = (cs + 32768) >>> 16;
	endfunction

	// phase of a 1024-step turn -> Q14 sine / cosine with quadrant folding
	function automatic void phase_sin_cos(input longint p, output longint s, output longint c);
		longint q4, quad, rem, a, b;
		q4   = 4 * (p % 1024);
		quad = (q4 / 1024) & 3;
		rem  = q4 % 1024;
		quarter_sin_cos((uvs_pkg::HALF_PI_Q30 * 64'(rem)) / 64'd1024, a, b);
		case (quad)
			0: begin s = a;  c = b;  end
			1: begin s = b;  c = -a; end
			2: begin s = -a; c = -b; end
			default: begin s = -b; c = a; end
		endcase
	endfunction

	// >> 14 rounded to nearest, ties away from zero
	function automatic longint round_q14(longint v);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + 8192) >>> 14;
		return v < 0 ? -m : m;
	endfunction

	function automatic vertex_t predict_vertex(grid_pt_t pt);
		vertex_t vx;
		longint segs, rings, ring, seg, pr, ps, sr, cr, ss, cs, nx, ny, nz;
		segs  = seg_count_q < 3 ? 3 : seg_count_q;     // degenerate counts widen
		rings = ring_count_q < 1 ? 1 : ring_count_q;
		ring  = pt.ring > rings + 1 ? rings + 1 : pt.ring;  // clamp to the poles
		seg   = pt.seg > segs ? segs : pt.seg;              // clamp to the seam
		pr = (2 * ring * 1024 + 2 * (rings + 1)) / (4 * (rings + 1));
		ps = ((2 * seg * 1024 + segs) / (2 * segs)) % 1024;
		phase_sin_cos(pr, sr, cr);
		phase_sin_cos(ps, ss, cs);
		nx = round_q14(sr * ss);
		ny = cr;
		nz = round_q14(sr * cs);
		vx.pos_x = 17'(round_q14(nx * longint'(radius_q)));
		vx.pos_y = 17'(round_q14(ny * longint'(radius_q)));
		vx.pos_z = 17'(round_q14(nz * longint'(radius_q)));
		vx.nrm_x = 16'(nx);
		vx.nrm_y = 16'(ny);
		vx.nrm_z = 16'(nz);
		vx.tan_x = 16'(cs);
		vx.tan_z = 16'(-ss);
		vx.tu    = 15'((2 * seg * 16384 + segs) / (2 * segs));
		vx.tv    = 15'((2 * ring * 16384 + rings + 1) / (2 * (rings + 1)));
		vx.vnum  = 20'(ring * (segs + 1) + seg);
		vx.quad  = (ring <= rings && seg < segs);
		return vx;
	endfunction

	// ---------------------------------------------------------------- driver
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			gap_left   <= 0;
		end else begin
			if (item_valid && !item_stall)
				expected_vertices.push_back(predict_vertex('{ring_index, segment_index}));
			if (item_valid && item_stall) begin
				// hold the stalled transaction
			end else if (gap_left > 0) begin
				gap_left   <= gap_left - 1;
				item_valid <= 1'b0;
			end else if (pending_pts.size() > 0) begin
				grid_pt_t pt;
				pt = pending_pts.pop_front();
				item_valid    <= 1'b1;
				ring_index    <= pt.ring;
				segment_index <= pt.seg;
				gap_left      <= pick_gap();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_stall <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (vertex_valid && !vertex_stall) begin
				if (expected_vertices.size() == 0) begin
					$display("%0t: unexpected vertex, number %0d", $time, vertex_number);
					fail_count++;
				end else begin
					vertex_t e;
					e = expected_vertices.pop_front();
					check_field("position_x", e.pos_x, position_x);
					check_field("position_y", e.pos_y, position_y);
					check_field("position_z", e.pos_z, position_z);
					check_field("normal_x", e.nrm_x, normal_x);
					check_field("normal_y", e.nrm_y, normal_y);
					check_field("normal_z", e.nrm_z, normal_z);
					check_field("tangent_x", e.tan_x, tangent_x);
					check_field("tangent_z", e.tan_z, tangent_z);
					check_field("tex_u", e.tu, tex_u);
					check_field("tex_v", e.tv, tex_v);
					check_field("vertex_number", e.vnum, vertex_number);
					check_field("quad_starts", e.quad, quad_starts);
				end
			end
			// back-pressure: mostly short bursts, a few long holds
			if (stall_left > 0) begin
				stall_left   <= stall_left - 1;
				vertex_stall <= 1'b1;
			end else if (steady || $urandom_range(0, 99) < 65) begin
				vertex_stall <= 1'b0;
			end else begin
				vertex_stall <= 1'b1;
				stall_left   <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
					: $urandom_range(0, 3);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (vertex_valid && !vertex_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[uv_sphere_vertex_generator] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic apb_write(uvs_pkg::reg_idx_t idx, int unsigned value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(int unsigned segs, int unsigned rings, int unsigned rad);
		apb_write(uvs_pkg::REG_SEGMENT_COUNT, segs);
		apb_write(uvs_pkg::REG_RING_COUNT, rings);
		apb_write(uvs_pkg::REG_RADIUS_SCALE, rad);
		seg_count_q  = segs & 10'h3FF;
		ring_count_q = rings & 10'h3FF;
		radius_q     = rad & 15'h7FFF;
	endtask

	// wait until every vertex is back, then let the pipeline settle
	task automatic drain();
		while (pending_pts.size() > 0 || item_valid || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_pt(int unsigned ring, int unsigned seg);
		pending_pts.push_back('{10'(ring), 10'(seg)});
	endtask

	// mostly legal grid points, some anywhere in the 10-bit field
	task automatic add_random(int count);
		int unsigned segs, rings;
		segs  = seg_count_q < 3 ? 3 : seg_count_q;
		rings = ring_count_q < 1 ? 1 : ring_count_q;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 8)
				add_pt($urandom_range(0, rings + 1 > 1023 ? 1023 : rings + 1),
					$urandom_range(0, segs));
			else
				add_pt($urandom_range(0, 1023), $urandom_range(0, 1023));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset configuration: poles, seam, clamps, field extremes
		add_pt(0, 0);     add_pt(101, 100);  add_pt(1023, 1023);
		add_pt(50, 25);   add_pt(100, 99);   add_pt(1, 50);
		add_pt(51, 75);   add_pt(101, 0);    add_pt(0, 1023);
		add_pt(682, 341); add_pt(341, 682);  add_pt(100, 100);
		drain();

		// smallest counts and radius, then register values below the minimum
		configure(3, 1, 1);
		add_pt(0, 0); add_pt(1, 1); add_pt(2, 2); add_pt(2, 3); add_pt(1023, 1023);
		drain();
		configure(0, 0, 0);
		add_pt(1, 1); add_pt(2, 3); add_pt(3, 4);
		add_random(60);
		drain();

		// largest values, no idling anywhere
		configure(1023, 1023, 32767);
		steady = 1'b1;
		add_pt(1023, 1023); add_pt(512, 512); add_pt(0, 1022);
		add_random(100);
		drain();
		steady = 1'b0;

		configure(1023, 1021, 32767);
		add_random(100);
		drain();

		configure(100, 100, 6144);
		add_random(120);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			configure($urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 32767));
			add_random(110);
			drain();
		end

		if (fail_count == 0)
			$display("[uv_sphere_vertex_generator] OK");
		else
			$display("[uv_sphere_vertex_generator] ERROR");
		$finish;
	end
endmodule
